>>> hw/rtl/fvac_pkg.sv
package fvac_pkg;

    // Field widths
    localparam int GRID_W    = 10;
    localparam int FLOW_W    = 16;
    localparam int COORD_W   = 13;
    localparam int CFG_W     = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int LEN_W     = 8;
    localparam int SCALE_W   = 4;
    localparam int OFFSET_W  = 8;
    localparam int KIND_W    = 2;
    localparam int CLASS_W   = 2;

    // Flow fraction and end point arithmetic
    localparam int FRAC_BITS = 8;
    localparam int PROD_W    = FLOW_W + SCALE_W + 1;
    localparam int NUM_A_W   = GRID_W + FRAC_BITS + 2;
    localparam int NUM_B_W   = PROD_W + 1;
    localparam int NUM_W     = ((NUM_A_W > NUM_B_W) ? NUM_A_W : NUM_B_W) + 1;
    localparam int Q_W       = NUM_W - FRAC_BITS - 1;
    localparam int COORD_MIN = -(2 ** (COORD_W - 1));
    localparam int COORD_MAX = (2 ** (COORD_W - 1)) - 1;

    // Length check
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int ML2_W     = 2 * LEN_W;

    // Accumulators
    localparam int MAX_VECTORS = 4096;
    localparam int CNT_W     = $clog2(MAX_VECTORS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VECTORS);
    localparam int SUM_W     = COORD_W + CNT_W;
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIV_CNT_W = $clog2(MAG_W + 1);

    // Report kinds
    localparam logic [KIND_W-1:0] KIND_VECTOR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOWARDS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_AWAY    = 2'd2;

    // Vector classes
    localparam logic [CLASS_W-1:0] CLASS_NEUTRAL = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_TOWARDS = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_AWAY    = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BORDER_START_X = 3'd0,
        REG_BORDER_START_Y = 3'd1,
        REG_BORDER_END_X   = 3'd2,
        REG_BORDER_END_Y   = 3'd3,
        REG_BAND_DISTANCE  = 3'd4,
        REG_MIN_LENGTH     = 3'd5,
        REG_FLOW_SCALE     = 3'd6,
        REG_ARROW_OFFSET   = 3'd7
    } cfg_idx_t;

    // Register reset values
    localparam logic [GRID_W-1:0]   RST_BORDER_START_X = 10'd0;
    localparam logic [GRID_W-1:0]   RST_BORDER_START_Y = 10'd0;
    localparam logic [GRID_W-1:0]   RST_BORDER_END_X   = 10'd1023;
    localparam logic [GRID_W-1:0]   RST_BORDER_END_Y   = 10'd0;
    localparam logic [GRID_W-1:0]   RST_BAND_DISTANCE  = 10'd50;
    localparam logic [LEN_W-1:0]    RST_MIN_LENGTH     = 8'd3;
    localparam logic [SCALE_W-1:0]  RST_FLOW_SCALE     = 4'd2;
    localparam logic [OFFSET_W-1:0] RST_ARROW_OFFSET   = 8'd25;

    // Input stream payload, first field in the low bits
    localparam int IN_DATA_W = 56;
    typedef struct packed {
        logic [IN_DATA_W-2*GRID_W-2*FLOW_W-1:0] pad;
        logic signed [FLOW_W-1:0]               flow_dy;
        logic signed [FLOW_W-1:0]               flow_dx;
        logic [GRID_W-1:0]                      grid_y;
        logic [GRID_W-1:0]                      grid_x;
    } in_data_t;

    // Output stream payload, first field in the low bits
    localparam int OUT_DATA_W = 72;
    typedef struct packed {
        logic [OUT_DATA_W-CLASS_W-4*COORD_W-CNT_W-1:0] pad;
        logic [CNT_W-1:0]                        vector_count;
        logic signed [COORD_W-1:0]               end_y;
        logic signed [COORD_W-1:0]               end_x;
        logic signed [COORD_W-1:0]               start_y;
        logic signed [COORD_W-1:0]               start_x;
        logic [CLASS_W-1:0]                      vector_class;
    } out_data_t;

    // One result held in the output register
    typedef struct packed {
        logic [KIND_W-1:0]         report_kind;
        logic [CLASS_W-1:0]        vector_class;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [CNT_W-1:0]          vector_count;
        logic                      last_result;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       mul;
        logic       end_pt;
        logic       sq;
        logic       decide;
        logic       div_start;
        logic       div_store;
        logic       emit;
        logic [2:0] idx;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic item_last;
        logic div_done;
    } status_t;

endpackage

>>> hw/rtl/flow_vector_approach_classifier_top.sv
// Channel   | Dir | Signals                         | Content
// s_axis    | in  | tvalid tready tdata tlast       | one flow vector, tlast = frame end
// m_axis    | out | tvalid tready tdata tuser tlast | vector report or class average
// cfg       | in  | cfg_we cfg_addr cfg_data        | register writes, no read-back
//
// A vector passes through load, flow multiply, end point, squares and classify;
// its report enters the output register in the classify step and, unless it ends a
// frame, the next vector can be taken the cycle after. A frame end adds 8 divisions
// in the shared one-bit-per-cycle divider, plus a towards and an away average report.
// Reset (rst_n, async, active low) clears accumulators and loads register defaults.
// A stalled m_axis holds the block in the classify or report step.
module flow_vector_approach_classifier_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // grid_x, grid_y, flow_dx, flow_dy, pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // vector_class, start_x, start_y, end_x, end_y,
                                        // vector_count, pad
    output logic [1:0]  m_axis_tuser,   // report_kind
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [9:0]  cfg_data
);

    fvac_pkg::cmd_t      cmd;
    fvac_pkg::status_t   sts;
    fvac_pkg::result_t   res;
    fvac_pkg::out_data_t out_word;

    fvac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fvac_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_data    (fvac_pkg::in_data_t'(s_axis_tdata)),
        .in_last    (s_axis_tlast),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_axis_tvalid),
        .out_result (res),
        .out_ready  (m_axis_tready)
    );

    // Pack the result onto the output stream
    always_comb
    begin
        out_word.pad          = '0;
        out_word.vector_class = res.vector_class;
        out_word.start_x      = res.start_x;
        out_word.start_y      = res.start_y;
        out_word.end_x        = res.end_x;
        out_word.end_y        = res.end_y;
        out_word.vector_count = res.vector_count;
    end

    assign m_axis_tdata = out_word;
    assign m_axis_tuser = res.report_kind;
    assign m_axis_tlast = res.last_result;

endmodule

>>> hw/rtl/fvac_div.sv
module fvac_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [fvac_pkg::SUM_W-1:0]  dividend,
    input  logic [fvac_pkg::CNT_W-1:0]         divisor,
    output logic                               done,
    output logic signed [fvac_pkg::COORD_W-1:0] quotient
);

    logic [fvac_pkg::MAG_W-1:0]     quo_reg, quo_next;
    logic [fvac_pkg::CNT_W:0]       rem_reg, rem_next;
    logic [fvac_pkg::CNT_W-1:0]     dvs_reg;
    logic [fvac_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           neg_reg;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [fvac_pkg::SUM_W-1:0]     mag_in;
    logic [fvac_pkg::CNT_W:0]       shifted;
    logic [fvac_pkg::CNT_W+1:0]     diff;
    logic [fvac_pkg::COORD_W-1:0]   q_mag;

    // Magnitude of the signed dividend
    assign mag_in = dividend[fvac_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;

    // One restoring step per cycle
    assign shifted = {rem_reg[fvac_pkg::CNT_W-1:0], quo_reg[fvac_pkg::MAG_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = mag_in[fvac_pkg::MAG_W-1:0];
            rem_next  = '0;
            cnt_next  = fvac_pkg::DIV_CNT_W'(fvac_pkg::MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (diff[fvac_pkg::CNT_W+1])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[fvac_pkg::MAG_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[fvac_pkg::CNT_W:0];
                quo_next = {quo_reg[fvac_pkg::MAG_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == fvac_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
            neg_reg <= dividend[fvac_pkg::SUM_W-1];
        end
    end

    // Averages stay within the coordinate range, so the low bits suffice
    assign q_mag    = quo_reg[fvac_pkg::COORD_W-1:0];
    assign quotient = neg_reg ? $signed(~q_mag + 1'b1) : $signed(q_mag);
    assign done     = done_reg;

endmodule

>>> hw/rtl/fvac_dp.sv
module fvac_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fvac_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [fvac_pkg::CFG_W-1:0]          cfg_data,
    input  fvac_pkg::in_data_t                  in_data,
    input  logic                                in_last,
    input  fvac_pkg::cmd_t                      cmd,
    output fvac_pkg::status_t                   sts,
    output logic                                out_valid,
    output fvac_pkg::result_t                   out_result,
    input  logic                                out_ready
);

    localparam logic [fvac_pkg::NUM_W-1:0] ROUND_C = fvac_pkg::NUM_W'(1) << fvac_pkg::FRAC_BITS;
    localparam logic [fvac_pkg::NUM_W-1:0] TRUNC_C =
        (fvac_pkg::NUM_W'(1) << (fvac_pkg::FRAC_BITS + 1)) - 1'b1;

    // Configuration registers
    logic [fvac_pkg::GRID_W-1:0]   bsx_reg, bsy_reg, bex_reg, bey_reg, band_reg;
    logic [fvac_pkg::LEN_W-1:0]    min_len_reg;
    logic [fvac_pkg::SCALE_W-1:0]  scale_reg;
    logic [fvac_pkg::OFFSET_W-1:0] offset_reg;

    // Item pipeline registers
    logic [fvac_pkg::GRID_W-1:0]        sx_reg, sy_reg;
    logic signed [fvac_pkg::FLOW_W-1:0] fdx_reg, fdy_reg;
    logic                               last_reg;
    logic signed [fvac_pkg::PROD_W-1:0] px_reg, py_reg;
    logic signed [fvac_pkg::COORD_W-1:0] ex_reg, ey_reg;
    logic signed [fvac_pkg::SQ_W-1:0]   dx2_reg, dy2_reg;
    logic [fvac_pkg::ML2_W-1:0]         ml2_reg;
    logic                               span_ok_reg, band_ok_reg, down_reg, up_reg;

    // Accumulators and averages
    logic signed [fvac_pkg::SUM_W-1:0]   tw_sum_reg [4];
    logic signed [fvac_pkg::SUM_W-1:0]   aw_sum_reg [4];
    logic [fvac_pkg::CNT_W-1:0]          tw_cnt_reg, aw_cnt_reg;
    logic signed [fvac_pkg::COORD_W-1:0] avg_reg [4];

    // Output register
    logic                out_valid_reg, out_valid_next;
    fvac_pkg::result_t   out_reg, out_next;

    logic signed [fvac_pkg::PROD_W-1:0]  px_c, py_c;
    logic signed [fvac_pkg::DIFF_W-1:0]  dx_c, dy_c, db1_c, db2_c;
    logic [fvac_pkg::DIFF_W-1:0]         ab1_c, ab2_c;
    logic [fvac_pkg::SQ_W:0]             len2_c;
    logic                                ok_c, tw_c, aw_c;
    logic [fvac_pkg::CLASS_W-1:0]        cls_c;
    logic signed [fvac_pkg::SUM_W-1:0]   coord_c [4];
    logic signed [fvac_pkg::SUM_W-1:0]   div_dividend;
    logic [fvac_pkg::CNT_W-1:0]          div_divisor;
    logic                                div_done;
    logic signed [fvac_pkg::COORD_W-1:0] div_quot;
    logic                                emit_away;
    logic [fvac_pkg::CNT_W-1:0]          emit_cnt;
    logic signed [fvac_pkg::COORD_W-1:0] emit_sy;
    logic signed [fvac_pkg::COORD_W-1:0] sx_c, sy_c;

    // start + scale*flow/2^F + 1/2, truncated toward zero, saturated
    function automatic logic signed [fvac_pkg::COORD_W-1:0] end_coord(
        input logic [fvac_pkg::GRID_W-1:0]        start,
        input logic signed [fvac_pkg::PROD_W-1:0] prod
    );
        logic signed [fvac_pkg::NUM_W-1:0] num;
        logic signed [fvac_pkg::NUM_W-1:0] adj;
        logic signed [fvac_pkg::Q_W-1:0]   q;
        logic signed [fvac_pkg::COORD_W-1:0] res;
        num = fvac_pkg::NUM_W'({start, {(fvac_pkg::FRAC_BITS + 1){1'b0}}})
            + (fvac_pkg::NUM_W'(prod) <<< 1) + ROUND_C;
        adj = num + (num[fvac_pkg::NUM_W-1] ? TRUNC_C : '0);
        q   = fvac_pkg::Q_W'(adj >>> (fvac_pkg::FRAC_BITS + 1));
        if (q < fvac_pkg::COORD_MIN)
        begin
            res = fvac_pkg::COORD_W'(fvac_pkg::COORD_MIN);
        end
        else if (q > fvac_pkg::COORD_MAX)
        begin
            res = fvac_pkg::COORD_W'(fvac_pkg::COORD_MAX);
        end
        else
        begin
            res = fvac_pkg::COORD_W'(q);
        end
        return res;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsx_reg     <= fvac_pkg::RST_BORDER_START_X;
            bsy_reg     <= fvac_pkg::RST_BORDER_START_Y;
            bex_reg     <= fvac_pkg::RST_BORDER_END_X;
            bey_reg     <= fvac_pkg::RST_BORDER_END_Y;
            band_reg    <= fvac_pkg::RST_BAND_DISTANCE;
            min_len_reg <= fvac_pkg::RST_MIN_LENGTH;
            scale_reg   <= fvac_pkg::RST_FLOW_SCALE;
            offset_reg  <= fvac_pkg::RST_ARROW_OFFSET;
        end
        else if (cfg_we)
        begin
            case (fvac_pkg::cfg_idx_t'(cfg_addr))
                fvac_pkg::REG_BORDER_START_X: bsx_reg     <= cfg_data;
                fvac_pkg::REG_BORDER_START_Y: bsy_reg     <= cfg_data;
                fvac_pkg::REG_BORDER_END_X:   bex_reg     <= cfg_data;
                fvac_pkg::REG_BORDER_END_Y:   bey_reg     <= cfg_data;
                fvac_pkg::REG_BAND_DISTANCE:  band_reg    <= cfg_data;
                fvac_pkg::REG_MIN_LENGTH:     min_len_reg <= cfg_data[fvac_pkg::LEN_W-1:0];
                fvac_pkg::REG_FLOW_SCALE:     scale_reg   <= cfg_data[fvac_pkg::SCALE_W-1:0];
                fvac_pkg::REG_ARROW_OFFSET:   offset_reg  <= cfg_data[fvac_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Scaled flow products
    assign px_c = $signed({1'b0, scale_reg}) * fdx_reg;
    assign py_c = $signed({1'b0, scale_reg}) * fdy_reg;

    // Differences for length and band checks
    assign dx_c  = fvac_pkg::DIFF_W'(ex_reg) - $signed({4'b0000, sx_reg});
    assign dy_c  = fvac_pkg::DIFF_W'(ey_reg) - $signed({4'b0000, sy_reg});
    assign db1_c = fvac_pkg::DIFF_W'(ey_reg) - $signed({4'b0000, bsy_reg});
    assign db2_c = fvac_pkg::DIFF_W'(ey_reg) - $signed({4'b0000, bey_reg});
    assign ab1_c = db1_c[fvac_pkg::DIFF_W-1] ? (~db1_c + 1'b1) : db1_c;
    assign ab2_c = db2_c[fvac_pkg::DIFF_W-1] ? (~db2_c + 1'b1) : db2_c;

    // Item pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg   <= in_data.grid_x;
            sy_reg   <= in_data.grid_y;
            fdx_reg  <= in_data.flow_dx;
            fdy_reg  <= in_data.flow_dy;
            last_reg <= in_last;
        end
        if (cmd.mul)
        begin
            px_reg <= px_c;
            py_reg <= py_c;
        end
        if (cmd.end_pt)
        begin
            ex_reg <= end_coord(sx_reg, px_reg);
            ey_reg <= end_coord(sy_reg, py_reg);
        end
        if (cmd.sq)
        begin
            dx2_reg     <= dx_c * dx_c;
            dy2_reg     <= dy_c * dy_c;
            ml2_reg     <= min_len_reg * min_len_reg;
            span_ok_reg <= (ex_reg >= $signed({3'b000, bsx_reg}))
                        && (ex_reg <= $signed({3'b000, bex_reg}));
            band_ok_reg <= (ab1_c < {4'b0000, band_reg}) || (ab2_c < {4'b0000, band_reg});
            down_reg    <= ey_reg > $signed({3'b000, sy_reg});
            up_reg      <= ey_reg < $signed({3'b000, sy_reg});
        end
    end

    // Classification
    assign len2_c = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign ok_c   = (len2_c > (fvac_pkg::SQ_W + 1)'(ml2_reg)) && span_ok_reg && band_ok_reg;
    assign tw_c   = ok_c && down_reg;
    assign aw_c   = ok_c && up_reg;
    assign cls_c  = tw_c ? fvac_pkg::CLASS_TOWARDS :
                    aw_c ? fvac_pkg::CLASS_AWAY : fvac_pkg::CLASS_NEUTRAL;

    assign sx_c = fvac_pkg::COORD_W'(sx_reg);
    assign sy_c = fvac_pkg::COORD_W'(sy_reg);

    always_comb
    begin
        coord_c[0] = fvac_pkg::SUM_W'(sx_reg);
        coord_c[1] = fvac_pkg::SUM_W'(sy_reg);
        coord_c[2] = fvac_pkg::SUM_W'(ex_reg);
        coord_c[3] = fvac_pkg::SUM_W'(ey_reg);
    end

    // Class accumulators, cleared when the away average is emitted
    assign emit_away = cmd.idx[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_cnt_reg <= '0;
            aw_cnt_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                tw_sum_reg[i] <= '0;
                aw_sum_reg[i] <= '0;
            end
        end
        else if (cmd.emit && emit_away)
        begin
            tw_cnt_reg <= '0;
            aw_cnt_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                tw_sum_reg[i] <= '0;
                aw_sum_reg[i] <= '0;
            end
        end
        else if (cmd.decide)
        begin
            if (tw_c && (tw_cnt_reg < fvac_pkg::MAX_CNT))
            begin
                tw_cnt_reg <= tw_cnt_reg + 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    tw_sum_reg[i] <= tw_sum_reg[i] + coord_c[i];
                end
            end
            if (aw_c && (aw_cnt_reg < fvac_pkg::MAX_CNT))
            begin
                aw_cnt_reg <= aw_cnt_reg + 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    aw_sum_reg[i] <= aw_sum_reg[i] + coord_c[i];
                end
            end
        end
    end

    // Shared divider for the eight averages
    assign div_dividend = cmd.idx[2] ? aw_sum_reg[cmd.idx[1:0]] : tw_sum_reg[cmd.idx[1:0]];
    assign div_divisor  = cmd.idx[2] ? aw_cnt_reg : tw_cnt_reg;

    fvac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            avg_reg[cmd.idx[1:0]] <= div_quot;
        end
    end

    // Average report fields
    assign emit_cnt = div_divisor;
    assign emit_sy  = emit_away ? (avg_reg[1] + $signed({5'b00000, offset_reg}))
                                : (avg_reg[1] - $signed({5'b00000, offset_reg}));

    // Output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.decide)
        begin
            out_valid_next            = 1'b1;
            out_next.report_kind      = fvac_pkg::KIND_VECTOR;
            out_next.vector_class     = cls_c;
            out_next.start_x          = sx_c;
            out_next.start_y          = sy_c;
            out_next.end_x            = ex_reg;
            out_next.end_y            = ey_reg;
            out_next.vector_count     = '0;
            out_next.last_result      = !last_reg;
        end
        else if (cmd.emit)
        begin
            out_valid_next            = 1'b1;
            out_next.report_kind      = emit_away ? fvac_pkg::KIND_AWAY : fvac_pkg::KIND_TOWARDS;
            out_next.vector_class     = fvac_pkg::CLASS_NEUTRAL;
            out_next.last_result      = emit_away;
            out_next.vector_count     = emit_cnt;
            if (emit_cnt == '0)
            begin
                out_next.start_x = '0;
                out_next.start_y = '0;
                out_next.end_x   = '0;
                out_next.end_y   = '0;
            end
            else
            begin
                out_next.start_x = avg_reg[0];
                out_next.start_y = emit_sy;
                out_next.end_x   = avg_reg[2];
                out_next.end_y   = avg_reg[3];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_result    = out_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.item_last = last_reg;
    assign sts.div_done  = div_done;

endmodule

>>> hw/rtl/fvac_ctrl.sv
module fvac_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fvac_pkg::status_t sts,
    output fvac_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_END,
        S_SQ,
        S_DECIDE,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;

    // Next state and index
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:    state_next = S_END;
            S_END:    state_next = S_SQ;
            S_SQ:     state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (sts.out_free)
                begin
                    idx_next   = '0;
                    state_next = sts.item_last ? S_DIV_START : S_IDLE;
                end
            end
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    if (idx_reg[1:0] == 2'b11)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_DIV_START;
                    end
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (idx_reg[2])
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_DIV_START;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Command decode
    assign in_ready      = (state_reg == S_IDLE);
    assign cmd.load      = (state_reg == S_IDLE) && in_valid;
    assign cmd.mul       = (state_reg == S_MUL);
    assign cmd.end_pt    = (state_reg == S_END);
    assign cmd.sq        = (state_reg == S_SQ);
    assign cmd.decide    = (state_reg == S_DECIDE) && sts.out_free;
    assign cmd.div_start = (state_reg == S_DIV_START);
    assign cmd.div_store = (state_reg == S_DIV_WAIT) && sts.div_done;
    assign cmd.emit      = (state_reg == S_EMIT) && sts.out_free;
    assign cmd.idx       = idx_reg;

endmodule

>>> hw/rtl/fvac_checker.sv
module fvac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    fvac_pkg::out_data_t d;

    assign d = m_axis_tdata;

    // A waiting result is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    // One vector at a time: ready drops after each input transaction
    a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a vector is in work");

    // The away average always closes a frame
    a_away_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == fvac_pkg::KIND_AWAY) |-> m_axis_tlast)
        else $error("away average without tlast");

    // Between the two averages no new vector is taken
    a_towards_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == fvac_pkg::KIND_TOWARDS)
        |-> !m_axis_tlast && !s_axis_tready)
        else $error("towards average out of frame sequence");

    // Vector reports carry no count
    a_vec_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == fvac_pkg::KIND_VECTOR) |-> (d.vector_count == '0))
        else $error("vector report with nonzero count");

endmodule

bind flow_vector_approach_classifier_top fvac_checker u_fvac_checker (.*);
